@@ rtl/arsb_pkg.sv @@
package arsb_pkg;

  localparam int COEF_BITS = 16;
  localparam int COEF_W = COEF_BITS + 1;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_BITS;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_FIELD_W = 9;
  localparam int CH_OUT_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_COEFF = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_COEFF = 2'd2;

  localparam int RESET_CHANNEL_COUNT = 256;
  localparam logic [COEF_W-1:0] RESET_RISE_COEFF = 17'd32768;
  localparam logic [COEF_W-1:0] RESET_DECAY_COEFF = 17'd4096;

endpackage

@@ rtl/arsb_sample_if.sv @@
interface arsb_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ rtl/arsb_result_if.sv @@
interface arsb_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic [arsb_pkg::CH_OUT_W-1:0] channel_index;
  logic frame_end;

  modport source (output valid, output smoothed, output channel_index, output frame_end,
                  input ready);
  modport sink (input valid, input smoothed, input channel_index, input frame_end,
                output ready);
endinterface

@@ rtl/attack_release_smoother_bank.sv @@
// Attack/release smoother bank: one exponential smoother per channel, with a
// rise weight used when the sample is above the stored value and a decay
// weight otherwise. Samples enter on the samples channel; a position counter
// assigns each one to the next channel and wraps after channel_count samples.
// Each input transaction yields exactly one transaction on the results
// channel, carrying the floored smoothed value, the channel index and a flag
// marking the last channel of the frame.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Coefficients above 1.0 are held at 1.0; a channel count of
// zero acts as one. A sample accepted on the samples channel is registered
// in the update stage and then in the result register before it leaves.
// Throughput is one sample per cycle while the receiver keeps up, set by the
// single read-modify-write of the channel memory, with back-to-back updates
// to one channel forwarded. Reset clears the position, restores the register
// defaults and marks every channel as zero through a per-channel valid bit.
// When the receiver stalls, the result register holds and one more sample
// can still be taken into the update stage before samples.ready falls.
module attack_release_smoother_bank #(
  parameter int MAX_CHANNELS = 256,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [arsb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arsb_pkg::CFG_DATA_W-1:0] cfg_data,
  arsb_sample_if.sink samples,
  arsb_result_if.source results
);

  localparam int VW = SAMPLE_BITS + FRAC_BITS;
  localparam int CH_BITS = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_BITS = $clog2(MAX_CHANNELS + 1);
  localparam int RESET_COUNT = arsb_pkg::RESET_CHANNEL_COUNT > MAX_CHANNELS ?
                               MAX_CHANNELS : arsb_pkg::RESET_CHANNEL_COUNT;

  logic [CNT_BITS-1:0] count;
  logic [arsb_pkg::COEF_W-1:0] rise_coeff;
  logic [arsb_pkg::COEF_W-1:0] decay_coeff;
  logic [arsb_pkg::COUNT_FIELD_W-1:0] count_field;
  logic [arsb_pkg::COEF_W-1:0] coeff_field;

  logic [CH_BITS-1:0] position;
  logic [CH_BITS-1:0] position_next;
  logic last;

  logic [MAX_CHANNELS-1:0] written;

  logic s1_vld;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [CH_BITS-1:0] s1_ch;
  logic s1_last;
  logic s1_seen;
  logic s1_byp;
  logic signed [VW-1:0] s1_byp_val;

  logic out_vld;
  logic signed [SAMPLE_BITS-1:0] out_smoothed;
  logic [arsb_pkg::CH_OUT_W-1:0] out_ch;
  logic out_last;

  logic out_free;
  logic s1_move;
  logic accept;
  logic hazard;

  logic [VW-1:0] rdata;
  logic signed [VW-1:0] value;
  logic signed [VW-1:0] value_next;

  assign count_field = cfg_data[arsb_pkg::COUNT_FIELD_W-1:0];
  assign coeff_field = (cfg_data > arsb_pkg::COEF_ONE) ? arsb_pkg::COEF_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_BITS'(RESET_COUNT);
      rise_coeff <= arsb_pkg::RESET_RISE_COEFF;
      decay_coeff <= arsb_pkg::RESET_DECAY_COEFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        arsb_pkg::REG_CHANNEL_COUNT: begin
          if (count_field == '0) begin
            count <= CNT_BITS'(1);
          end else if (32'(count_field) > MAX_CHANNELS) begin
            count <= CNT_BITS'(MAX_CHANNELS);
          end else begin
            count <= CNT_BITS'(count_field);
          end
        end
        arsb_pkg::REG_RISE_COEFF: begin
          rise_coeff <= coeff_field;
        end
        arsb_pkg::REG_DECAY_COEFF: begin
          decay_coeff <= coeff_field;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_vld || results.ready;
  assign s1_move = s1_vld && out_free;
  assign samples.ready = !s1_vld || out_free;
  assign accept = samples.valid && samples.ready;
  assign hazard = s1_move && (s1_ch == position);

  assign last = (32'(position) + 32'd1) >= 32'(count);
  assign position_next = last ? '0 : CH_BITS'(32'(position) + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (s1_move) begin
      written[s1_ch] <= 1'b1;
    end
  end

  arsb_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_CHANNELS)
  ) u_ram (
    .clk(clk),
    .we(s1_move),
    .waddr(s1_ch),
    .wdata(value_next),
    .re(accept),
    .raddr(position),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (s1_move) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= samples.sample;
      s1_ch <= position;
      s1_last <= last;
      s1_seen <= written[position] || hazard;
      s1_byp <= hazard;
      s1_byp_val <= value_next;
    end
  end

  always_comb begin
    if (!s1_seen) begin
      value = '0;
    end else if (s1_byp) begin
      value = s1_byp_val;
    end else begin
      value = $signed(rdata);
    end
  end

  arsb_update #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_update (
    .sample(s1_sample),
    .value(value),
    .rise_coeff(rise_coeff),
    .decay_coeff(decay_coeff),
    .value_next(value_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (s1_move) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_smoothed <= value_next[VW-1:FRAC_BITS];
      out_ch <= arsb_pkg::CH_OUT_W'(s1_ch);
      out_last <= s1_last;
    end
  end

  assign results.valid = out_vld;
  assign results.smoothed = out_smoothed;
  assign results.channel_index = out_ch;
  assign results.frame_end = out_last;

endmodule

@@ rtl/arsb_ram.sv @@
module arsb_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/arsb_update.sv @@
module arsb_update #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] value,
  input  logic [arsb_pkg::COEF_W-1:0] rise_coeff,
  input  logic [arsb_pkg::COEF_W-1:0] decay_coeff,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] value_next
);

  localparam int VW = SAMPLE_BITS + FRAC_BITS;
  localparam int PW = VW + 1 + arsb_pkg::COEF_W + 1;

  logic signed [VW-1:0] x;
  logic signed [VW:0] d;
  logic [arsb_pkg::COEF_W-1:0] coeff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] step;

  always_comb begin
    x = {sample, {FRAC_BITS{1'b0}}};
    d = $signed({x[VW-1], x}) - $signed({value[VW-1], value});
    coeff = (!d[VW] && (d != '0)) ? rise_coeff : decay_coeff;
    prod = d * $signed({1'b0, coeff});
    step = prod >>> arsb_pkg::COEF_BITS;
    value_next = value + $signed(step[VW-1:0]);
  end

endmodule
